// ===== rtl/log_ratio_series_sum_macros.svh =====
// assertion helpers for the series sum block
`ifndef LOG_RATIO_SERIES_SUM_MACROS_SVH
`define LOG_RATIO_SERIES_SUM_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LRSS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("log_ratio_series_sum: assertion failed");
// next-cycle implication
`define LRSS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("log_ratio_series_sum: assertion failed");
`else
`define LRSS_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define LRSS_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== rtl/lrss_pkg.sv =====
package lrss_pkg;

	localparam int XW = 32;
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] TERM_COUNT_RESET = 7'd8;
	localparam logic [XW-1:0] ONE_Q16 = 32'h0001_0000;
	// 2^48 / ax starts with 2^16 as the partial remainder, then 32 zero bits
	localparam logic [XW-1:0] RECIP_REM = 32'h0001_0000;
	localparam logic [30:0] SAT_MAG = 31'h7FFF_FFFF;
	localparam int DIV_STEPS = 32;
	localparam int DIV_CW = 5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RECIP,
		ST_SQUARE,
		ST_SQSAVE,
		ST_DIV,
		ST_STEP,
		ST_FINISH
	} lrss_state_t;

	typedef struct packed {
		logic load;
		logic recip_start;
		logic recip_take;
		logic square_mul;
		logic r2_take;
		logic term_start;
		logic term_take;
		logic step_take;
		logic finish;
	} lrss_cmd_t;

	typedef struct packed {
		logic skip;
		logic div_done;
		logic last_term;
	} lrss_status_t;

endpackage

// ===== rtl/lrss_div.sv =====
module lrss_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [lrss_pkg::XW-1:0] rem_init,
	input  logic [lrss_pkg::XW-1:0] dividend_lo,
	input  logic [lrss_pkg::XW-1:0] divisor,
	output logic [lrss_pkg::XW-1:0] quotient,
	output logic                   done
);
	import lrss_pkg::*;

	localparam logic [DIV_CW-1:0] STEP_LAST = DIV_CW'(DIV_STEPS - 1);

	logic [XW-1:0]     rem_q;
	logic [XW-1:0]     quo_q;
	logic [XW-1:0]     den_q;
	logic [DIV_CW-1:0] step_q;
	logic              run_q;
	logic              done_q;
	logic [XW:0]       shifted;
	logic [XW:0]       diff;

	// restoring division, one quotient bit a cycle
	always_comb begin
		shifted = {rem_q, quo_q[XW-1]};
		diff = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_LAST) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= rem_init;
			quo_q <= dividend_lo;
			den_q <= divisor;
		end else if (run_q) begin
			if (diff[XW]) begin
				rem_q <= shifted[XW-1:0];
				quo_q <= {quo_q[XW-2:0], 1'b0};
			end else begin
				rem_q <= diff[XW-1:0];
				quo_q <= {quo_q[XW-2:0], 1'b1};
			end
		end
	end

	assign quotient = quo_q;
	assign done = done_q;

endmodule

// ===== rtl/lrss_datapath.sv =====
module lrss_datapath #(
	parameter int MAX_TERMS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lrss_pkg::lrss_cmd_t         cmd,
	output lrss_pkg::lrss_status_t      status,
	input  logic [lrss_pkg::XW-1:0]     x_value,
	input  logic [lrss_pkg::CFG_W-1:0]  term_count,
	output logic [lrss_pkg::XW-1:0]     series_sum,
	output logic                        out_of_domain,
	output logic                        result_valid
);
	import lrss_pkg::*;

	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam int AW = XW + CW + 3;

	logic [XW-1:0]   ax_in;
	logic [CW-1:0]   n_in;
	logic [XW-1:0]   ax_q;
	logic            neg_q;
	logic            ood_q;
	logic [CW-1:0]   n_q;
	logic [CW-1:0]   cnt_q;
	logic [XW-1:0]   p_q;
	logic [XW-1:0]   r2_q;
	logic [2*XW-1:0] prod_q;
	logic [AW-1:0]   acc_q;
	logic [XW-1:0]   mul_b;
	logic [XW-1:0]   div_rem;
	logic [XW-1:0]   div_lo;
	logic [XW-1:0]   div_den;
	logic [XW-1:0]   div_q;
	logic            div_done;
	logic            div_go;
	logic            sat;
	logic [30:0]     mag31;
	logic [XW-1:0]   mag32;
	logic [XW-1:0]   res;
	logic [XW-1:0]   series_sum_q;
	logic            ood_out_q;
	logic            valid_q;

	always_comb begin
		ax_in = x_value[XW-1] ? (XW'(0) - x_value) : x_value;
		if (int'(term_count) > MAX_TERMS) begin
			n_in = CW'(MAX_TERMS);
		end else begin
			n_in = CW'(term_count);
		end
	end

	// shared divider: 2^48 / ax once, then p / (2i+1) per term
	always_comb begin
		div_go = cmd.recip_start | cmd.term_start;
		if (cmd.recip_start) begin
			div_rem = RECIP_REM;
			div_lo = '0;
			div_den = ax_q;
		end else begin
			div_rem = '0;
			// the next power lands in p_q on this same edge, so take it from the product
			div_lo = cmd.step_take ? prod_q[2*XW-1:XW] : p_q;
			div_den = XW'({cnt_q, 1'b1});
		end
	end

	lrss_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (div_go),
		.rem_init    (div_rem),
		.dividend_lo (div_lo),
		.divisor     (div_den),
		.quotient    (div_q),
		.done        (div_done)
	);

	assign mul_b = cmd.square_mul ? p_q : r2_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q <= ax_in;
			neg_q <= x_value[XW-1];
			ood_q <= (ax_in <= ONE_Q16);
			n_q <= n_in;
			cnt_q <= '0;
			acc_q <= '0;
		end
		if (cmd.recip_take) begin
			p_q <= div_q;
		end
		if (cmd.square_mul || cmd.term_take) begin
			prod_q <= (2*XW)'(p_q) * (2*XW)'(mul_b);
		end
		if (cmd.r2_take) begin
			r2_q <= prod_q[2*XW-1:XW];
		end
		if (cmd.term_take) begin
			acc_q <= acc_q + AW'(div_q);
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.step_take) begin
			p_q <= prod_q[2*XW-1:XW];
		end
	end

	// doubled Q0.32 sum to Q4.28 is a right shift by three
	always_comb begin
		sat = |acc_q[AW-1:34];
		mag31 = sat ? SAT_MAG : acc_q[33:3];
		mag32 = {1'b0, mag31};
		res = neg_q ? (XW'(0) - mag32) : mag32;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			series_sum_q <= ood_q ? '0 : res;
			ood_out_q <= ood_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.finish;
		end
	end

	always_comb begin
		status.skip = ood_q | (n_q == '0);
		status.div_done = div_done;
		status.last_term = (cnt_q == n_q);
	end

	assign series_sum = series_sum_q;
	assign out_of_domain = ood_out_q;
	assign result_valid = valid_q;

endmodule

// ===== rtl/lrss_ctrl.sv =====
module lrss_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  lrss_pkg::lrss_status_t status,
	output lrss_pkg::lrss_cmd_t    cmd,
	output logic                   busy
);
	import lrss_pkg::*;

	lrss_state_t state_q;
	lrss_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.skip) begin
					state_d = ST_FINISH;
				end else begin
					cmd.recip_start = 1'b1;
					state_d = ST_RECIP;
				end
			end
			ST_RECIP: begin
				if (status.div_done) begin
					cmd.recip_take = 1'b1;
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				cmd.square_mul = 1'b1;
				state_d = ST_SQSAVE;
			end
			ST_SQSAVE: begin
				cmd.r2_take = 1'b1;
				cmd.term_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) begin
					cmd.term_take = 1'b1;
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.step_take = 1'b1;
				if (status.last_term) begin
					state_d = ST_FINISH;
				end else begin
					cmd.term_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/log_ratio_series_sum.sv =====
// Partial sum of 2/((2i+1) x^(2i+1)) for i below term_count, i.e. ln((x+1)/(x-1)),
// for a Q16.16 x, returned as signed Q4.28. Pulse start while busy is low to hand
// in x_value; the result shows on series_sum and out_of_domain for exactly one
// cycle with result_valid high, and there is no way to hold it off, so capture
// it then. For n terms (term_count capped at MAX_TERMS) the work falls to the
// shared 32-step restoring divider, which forms 1/|x| once and then divides
// each odd power by 2i+1, while the ST_STEP state forms the next power after
// each term; |x| <= 1 or n = 0 skip the divider and go straight to the result.
// busy drops in the cycle the result shows, so the next word can be taken
// right away. Write term_count only while busy is low.
module log_ratio_series_sum #(
	parameter int MAX_TERMS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [lrss_pkg::XW-1:0] x_value,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lrss_pkg::CFG_W-1:0]  term_count,
	output logic signed [lrss_pkg::XW-1:0] series_sum,
	output logic                        out_of_domain,
	output logic                        result_valid
);
	import lrss_pkg::*;

`include "log_ratio_series_sum_macros.svh"

	logic [CFG_W-1:0] term_count_q;
	lrss_cmd_t        cmd;
	lrss_status_t     status;
	logic [XW-1:0]    sum_w;

	assign cfg_ready = ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TERM_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			term_count_q <= term_count;
		end
	end

	lrss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	lrss_datapath #(
		.MAX_TERMS (MAX_TERMS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.x_value       (x_value),
		.term_count    (term_count_q),
		.series_sum    (sum_w),
		.out_of_domain (out_of_domain),
		.result_valid  (result_valid)
	);

	assign series_sum = sum_w;

	`LRSS_ASSERT_IMPL(a_strobe_idle, clk, arst_n, result_valid, !busy)
	`LRSS_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`LRSS_ASSERT_IMPL(a_ood_zero, clk, arst_n, result_valid && out_of_domain, series_sum == '0)
	`LRSS_ASSERT_NEXT(a_single_strobe, clk, arst_n, result_valid, !result_valid)

endmodule

// ===== tb/tb_log_ratio_series_sum.sv =====
module tb_log_ratio_series_sum;
	import lrss_pkg::*;

	localparam int TERM_LIMIT = 64;
	localparam int CYCLE_LIMIT = 3_000_000;

	typedef struct {
		logic [XW-1:0]    x;
		logic [CFG_W-1:0] terms;
		logic [XW-1:0]    sum;
		logic             ood;
	} series_word_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic signed [XW-1:0]     x_value = '0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_W-1:0]         term_count = '0;
	logic signed [XW-1:0]     series_sum;
	logic                     out_of_domain;
	logic                     result_valid;

	logic [XW-1:0]    pending_x[$];
	series_word_t     expected_sums[$];
	logic [CFG_W-1:0] term_model = TERM_COUNT_RESET;
	int               gap_pct = 0;
	int               mismatches = 0;
	int               words_taken = 0;
	int               words_checked = 0;
	int               divergent_seen = 0;
	int               settings_seen = 1;
	int               cycle_count = 0;

	log_ratio_series_sum #(
		.MAX_TERMS(TERM_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.x_value(x_value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.term_count(term_count),
		.series_sum(series_sum),
		.out_of_domain(out_of_domain),
		.result_valid(result_valid)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// truncating fixed-point series: 1/|x| once, odd powers by r^2, each over 2i+1
	function automatic series_word_t predict_series(input logic [XW-1:0] x,
			input logic [CFG_W-1:0] cnt);
		series_word_t w;
		logic [XW-1:0] ax;
		logic [63:0] recip;
		logic [63:0] r2;
		logic [63:0] pow;
		logic [63:0] acc;
		logic [63:0] mag;
		int nterms;
		w.x = x;
		w.terms = cnt;
		ax = x[XW-1] ? (~x + 1'b1) : x;
		nterms = (cnt > TERM_LIMIT) ? TERM_LIMIT : int'(cnt);
		if (ax <= ONE_Q16) begin
			w.sum = '0;
			w.ood = 1'b1;
		end else begin
			recip = (64'd1 << 48) / {32'd0, ax};
			r2 = (recip * recip) >> 32;
			pow = recip;
			acc = '0;
			for (int i = 0; i < nterms; i++) begin
				acc = acc + pow / 64'(2 * i + 1);
				pow = (pow * r2) >> 32;
			end
			mag = (acc << 1) >> 4;
			if (mag > 64'h7FFF_FFFF)
				mag = 64'h7FFF_FFFF;
			w.sum = x[XW-1] ? (32'd0 - mag[31:0]) : mag[31:0];
			w.ood = 1'b0;
		end
		return w;
	endfunction

	function automatic logic [XW-1:0] pick_x();
		logic [XW-1:0] m;
		case ($urandom_range(4))
			0: m = $urandom();
			1: m = ONE_Q16 + $urandom_range(255);
			2: m = ONE_Q16 + $urandom_range(32'h0003_FFFF);
			3: m = $urandom_range(32'h0001_0000);
			default: m = $urandom_range(32'h00FF_FFFF);
		endcase
		if ($urandom_range(1))
			m = ~m + 1'b1;
		return m;
	endfunction

	task automatic flag_mismatch(input string what, input logic [XW-1:0] x,
			input logic [XW-1:0] want, input logic [XW-1:0] got);
		$display("mismatch %s: x=%h want %h got %h", what, x, want, got);
		mismatches++;
	endtask

	// driver: start stays up until the word is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			x_value <= '0;
		end else begin
			if (start && !busy) begin
				expected_sums.push_back(predict_series(x_value, term_model));
				words_taken++;
			end
			if (!(start && busy)) begin
				if (pending_x.size() != 0 && $urandom_range(99) >= gap_pct) begin
					start <= 1'b1;
					x_value <= pending_x.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: results cannot be held off, so take them the cycle they show
	always @(posedge clk) begin
		series_word_t w;
		if (arst_n && result_valid) begin
			if (expected_sums.size() == 0) begin
				flag_mismatch("unexpected word", '0, '0, series_sum);
			end else begin
				w = expected_sums.pop_front();
				if (series_sum !== w.sum)
					flag_mismatch($sformatf("series_sum n=%0d", w.terms), w.x, w.sum,
						series_sum);
				if (out_of_domain !== w.ood)
					flag_mismatch($sformatf("out_of_domain n=%0d", w.terms), w.x,
						32'(w.ood), 32'(out_of_domain));
				if (w.ood)
					divergent_seen++;
				words_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
				expected_sums.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_x.size() != 0 || start || busy || expected_sums.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_terms(input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		term_count <= v;
		do @(posedge clk);
		while (!cfg_ready);
		term_model = v;
		settings_seen++;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int terms, input int count, input int gap);
		wait_drained();
		write_terms(CFG_W'(terms));
		@(negedge clk);
		gap_pct = gap;
		repeat (count) pending_x.push_back(pick_x());
	endtask

	initial begin
		logic [XW-1:0] edge_x[$];
		edge_x = '{32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0001,
			32'hFFFE_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
			32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000, 32'hFFFF_8000,
			32'h0000_FFFF, 32'h0003_0000, 32'h0010_0000, 32'h0000_0001,
			32'hFFFF_FFFF};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// edge values at the reset term count
		gap_pct = 35;
		foreach (edge_x[i]) pending_x.push_back(edge_x[i]);

		run_phase(1, 30, 35);
		run_phase($urandom_range(2, 16), 40, 35);
		// count above the cap saturates, then near-one and extreme arguments at that count
		run_phase(127, 6, 35);
		pending_x.push_back(32'h0001_0001);
		pending_x.push_back(32'hFFFE_FFFF);
		pending_x.push_back(32'h7FFF_FFFF);
		pending_x.push_back(32'h8000_0000);

		run_phase(0, 20, 73);
		run_phase($urandom_range(2, 16), 50, 73);
		run_phase(TERM_LIMIT, 6, 73);

		run_phase($urandom_range(1, 24), 60, 0);
		run_phase($urandom_range(2, 16), 34, 0);
		run_phase($urandom_range(100, 126), 4, 0);

		wait_drained();
		repeat (20) @(negedge clk);

		$display("%0d words checked over %0d term-count settings, %0d divergent",
			words_checked, settings_seen, divergent_seen);
		$display("term counts from zero through saturation, sender gaps 35/73/0 percent");
		if (mismatches == 0 && expected_sums.size() == 0 && words_checked == words_taken)
			begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d words outstanding", mismatches,
				expected_sums.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lrss_pkg.sv
rtl/lrss_div.sv
rtl/lrss_datapath.sv
rtl/lrss_ctrl.sv
rtl/log_ratio_series_sum.sv
tb/tb_log_ratio_series_sum.sv
